FILE: design/mtf_pkg.sv
// Shared types and constants for the move-to-front list.
package mtf_pkg;

    localparam int VALUE_W    = 32;
    localparam int STATUS_W   = 2;
    localparam int POSITION_W = 4;
    localparam int COUNT_W    = 5;
    localparam int DEPTH_DEF  = 16;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_MISS  = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    // per-cell control from the sequencer
    typedef struct packed {
        logic capture;  // latch compare result against incoming key
        logic shift;    // load data from the neighbor toward the front
        logic valid;    // cell holds a live entry
    } t_cell_ctrl;

endpackage

FILE: design/move_to_front_list_top.sv
// Top level of the move-to-front self-organizing list.
//
// Usage:
//   Command channel: drive i_kind / i_value and raise start; the item is
//   taken at a rising edge with start high and busy low. i_kind = 0 pushes
//   i_value at the front, i_kind = 1 looks it up and moves a hit to front.
//   Result channel: o_done is high for exactly one cycle with o_status,
//   o_position and o_entry_count valid; the receiver cannot stall it.
// Sequence:
//   The accepting edge takes the item and every cell latches its compare with the key.
//   While busy is high the sequencer picks the first match from the front, shifts the cells in front
//   of it back by one (or all cells for a push) and registers the result.
//   o_done is registered from busy, so it is high together with the registered result.
//   busy is high for one cycle, and no new item is taken while it is high; the compare in
//   the cells and the shift of the same cells share the row.
// Reset:
//   i_rst_n (synchronous, active low) empties the list and clears busy and
//   o_done. Cell contents are not cleared; only live cells take part.
module move_to_front_list_top
    import mtf_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  i_kind,
    input  logic [VALUE_W-1:0]    i_value,
    output logic                  o_done,
    output logic [STATUS_W-1:0]   o_status,
    output logic [POSITION_W-1:0] o_position,
    output logic [COUNT_W-1:0]    o_entry_count
);

    // cell row: index 0 is the front of the list
    t_cell_ctrl         cell_ctrl [DEPTH];
    logic [VALUE_W-1:0] cell_data [DEPTH];
    logic [DEPTH-1:0]   cell_match;
    logic [VALUE_W-1:0] key;

    mtf_ctrl #(
        .DEPTH(DEPTH)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_kind        (i_kind),
        .i_value       (i_value),
        .i_match       (cell_match),
        .o_cell        (cell_ctrl),
        .o_key         (key),
        .o_done        (o_done),
        .o_status      (o_status),
        .o_position    (o_position),
        .o_entry_count (o_entry_count)
    );

    // each cell compares with the incoming value at accept and, on shift,
    // loads from its front neighbor; the front cell loads the held key
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        mtf_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (cell_ctrl[g]),
            .i_key   (i_value),
            .i_prev  ((g == 0) ? key : cell_data[(g == 0) ? 0 : g - 1]),
            .o_data  (cell_data[g]),
            .o_match (cell_match[g])
        );
    end

endmodule

FILE: design/mtf_cell.sv
// One list cell: holds an entry, compares it with the key, shifts from its neighbor.
module mtf_cell
    import mtf_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cell_ctrl         i_ctrl,
    input  logic [VALUE_W-1:0] i_key,
    input  logic [VALUE_W-1:0] i_prev,
    output logic [VALUE_W-1:0] o_data,
    output logic               o_match
);

    logic [VALUE_W-1:0] r_data;
    logic               r_match;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift) begin
            r_data <= i_prev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match <= 1'b0;
        end else if (i_ctrl.capture) begin
            r_match <= i_ctrl.valid && (r_data == i_key);
        end
    end

    assign o_data  = r_data;
    assign o_match = r_match;

endmodule

FILE: design/mtf_ctrl.sv
// Sequencer: item capture, first-match select, shift enables, count and result.
module mtf_ctrl
    import mtf_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  i_kind,
    input  logic [VALUE_W-1:0]    i_value,
    input  logic [DEPTH-1:0]      i_match,
    output t_cell_ctrl            o_cell [DEPTH],
    output logic [VALUE_W-1:0]    o_key,
    output logic                  o_done,
    output logic [STATUS_W-1:0]   o_status,
    output logic [POSITION_W-1:0] o_position,
    output logic [COUNT_W-1:0]    o_entry_count
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = $clog2(DEPTH);

    logic               r_busy;
    logic               r_kind;
    logic [VALUE_W-1:0] r_key;
    logic [CW-1:0]      r_count, n_count;
    logic               r_done;
    t_status            r_status, n_status;
    logic [PW-1:0]      r_pos, n_pos;

    logic               accept;
    logic [DEPTH-1:0]   first;
    logic [DEPTH-1:0]   shift;
    logic [PW-1:0]      hit_pos;
    logic               found;

    assign accept = start && !r_busy;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind <= i_kind;
            r_key  <= i_value;
        end
    end

    // isolate lowest set match bit, then encode it
    always_comb begin
        first   = i_match & (~i_match + DEPTH'(1));
        found   = |i_match;
        hit_pos = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (first[i]) begin
                hit_pos = hit_pos | PW'(i);
            end
        end
    end

    always_comb begin
        n_count  = r_count;
        n_status = ST_OK;
        n_pos    = '0;
        shift    = '0;
        if (r_busy) begin
            if (!r_kind) begin
                if (r_count == CW'(DEPTH)) begin
                    n_status = ST_FULL;
                end else begin
                    shift   = '1;
                    n_count = r_count + CW'(1);
                end
            end else if (r_count == '0) begin
                n_status = ST_EMPTY;
            end else if (!found) begin
                n_status = ST_MISS;
            end else begin
                shift = first | (first - DEPTH'(1));  // cells 0 .. hit
                n_pos = hit_pos;
            end
        end
    end

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            o_cell[i].capture = accept;
            o_cell[i].shift   = shift[i];
            o_cell[i].valid   = (CW'(i) < r_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= r_busy;
            if (accept) begin
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_busy  <= 1'b0;
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_status <= n_status;
            r_pos    <= n_pos;
        end
    end

    assign busy          = r_busy;
    assign o_key         = r_key;
    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_position    = POSITION_W'(r_pos);
    assign o_entry_count = COUNT_W'(r_count);

endmodule

FILE: bench/move_to_front_list_top_tb.sv
// Self-checking bench for the move-to-front list: directed and random push/lookup items.
module move_to_front_list_top_tb;
    import mtf_pkg::*;

    localparam int DEPTH = DEPTH_DEF;
    localparam int RANDOM_ITEMS = 600;
    // Worst case is about 625 items, each with its longest idle gap and busy time; keep a wide margin.
    localparam int CYCLE_LIMIT = 200000;
    // Drain time after the last result, to catch any stray o_done.
    localparam int DRAIN_CYCLES = 10;

    localparam logic KIND_PUSH   = 1'b0;
    localparam logic KIND_LOOKUP = 1'b1;

    typedef struct {
        logic               kind;
        logic [VALUE_W-1:0] value;
    } t_item;

    typedef struct {
        t_status               status;
        logic [POSITION_W-1:0] position;
        logic [COUNT_W-1:0]    entry_count;
    } t_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic                  i_kind = KIND_PUSH;
    logic [VALUE_W-1:0]    i_value = '0;
    logic                  o_done;
    logic [STATUS_W-1:0]   o_status;
    logic [POSITION_W-1:0] o_position;
    logic [COUNT_W-1:0]    o_entry_count;

    move_to_front_list_top #(.DEPTH(DEPTH)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_kind        (i_kind),
        .i_value       (i_value),
        .o_done        (o_done),
        .o_status      (o_status),
        .o_position    (o_position),
        .o_entry_count (o_entry_count)
    );

    // Items waiting to be driven, and results owed by the block in order.
    t_item   cmd_queue[$];
    t_result due_results[$];

    // Shadow of the list as the block should hold it.
    logic [VALUE_W-1:0] shadow_cells[DEPTH];
    int                 shadow_held = 0;

    // Generation-side bookkeeping: which values made it into the list.
    logic [VALUE_W-1:0] stored_keys[$];
    int                 gen_held = 0;

    int n_fail = 0;
    int n_checked = 0;
    int n_stored = 0, n_full = 0, n_hit = 0, n_miss = 0, n_empty = 0;
    int cycles = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Reset once, at the start.
    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Apply one accepted item to the shadow list and queue the result it owes.
    function automatic void mtf_shadow_apply(t_item it);
        t_result r;
        int      hit;
        r.status   = ST_OK;
        r.position = '0;
        hit        = -1;
        if (it.kind == KIND_PUSH) begin
            if (shadow_held >= DEPTH) begin
                r.status = ST_FULL;
                n_full++;
            end else begin
                for (int i = shadow_held; i > 0; i--) shadow_cells[i] = shadow_cells[i-1];
                shadow_cells[0] = it.value;
                shadow_held++;
                n_stored++;
            end
        end else if (shadow_held == 0) begin
            r.status = ST_EMPTY;
            n_empty++;
        end else begin
            // first match from the front wins
            for (int i = 0; i < shadow_held; i++)
                if (hit < 0 && shadow_cells[i] == it.value) hit = i;
            if (hit < 0) begin
                r.status = ST_MISS;
                n_miss++;
            end else begin
                for (int i = hit; i > 0; i--) shadow_cells[i] = shadow_cells[i-1];
                shadow_cells[0] = it.value;
                r.position = POSITION_W'(hit);
                n_hit++;
            end
        end
        r.entry_count = COUNT_W'(shadow_held);
        due_results.push_back(r);
    endfunction

    // Queue an item for the driver; track which pushes will land in the list.
    function automatic void add_item(logic kind, logic [VALUE_W-1:0] value);
        t_item it;
        it.kind  = kind;
        it.value = value;
        cmd_queue.push_back(it);
        if (kind == KIND_PUSH && gen_held < DEPTH) begin
            gen_held++;
            stored_keys.push_back(value);
        end
    endfunction

    // Driver: holds start until the item is taken, then idles a random while.
    t_item cur_item;
    int    idle_left = 0;
    logic  burst_mode = 1'b0;

    always @(posedge i_clk) begin : driver
        logic taken;
        int   r;
        taken = start && !busy;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (taken) begin
                mtf_shadow_apply(cur_item);
                // occasionally switch between back-to-back bursts and gappy traffic
                if ($urandom_range(0, 99) < 4) burst_mode = !burst_mode;
                r = $urandom_range(0, 99);
                if (burst_mode)  idle_left = 0;
                else if (r < 50) idle_left = $urandom_range(0, 1);
                else if (r < 90) idle_left = $urandom_range(1, 4);
                else             idle_left = $urandom_range(5, 25);
            end
            if (start && !taken) begin
                // hold the item steady while busy
            end else if (idle_left > 0 || cmd_queue.size() == 0) begin
                if (idle_left > 0) idle_left--;
                start   <= 1'b0;
                // junk on the payload while start is low must be ignored
                i_kind  <= 1'($urandom);
                i_value <= $urandom;
            end else begin
                cur_item = cmd_queue.pop_front();
                start   <= 1'b1;
                i_kind  <= cur_item.kind;
                i_value <= cur_item.value;
            end
        end
    end

    // Monitor: every o_done strobe is checked against the oldest owed result.
    always @(posedge i_clk) begin : monitor
        t_result want;
        if (i_rst_n && o_done) begin
            if (due_results.size() == 0) begin
                $error("unexpected result: status %0d position %0d entry_count %0d",
                       o_status, o_position, o_entry_count);
                n_fail++;
            end else begin
                want = due_results.pop_front();
                n_checked++;
                if (o_status !== want.status) begin
                    $error("status: expected %s actual %0d", want.status.name(), o_status);
                    n_fail++;
                end
                if (o_position !== want.position) begin
                    $error("position: expected %0d actual %0d", want.position, o_position);
                    n_fail++;
                end
                if (o_entry_count !== want.entry_count) begin
                    $error("entry_count: expected %0d actual %0d",
                           want.entry_count, o_entry_count);
                    n_fail++;
                end
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin : stimulus
        int r;
        // Directed: empty lookup, field extremes, duplicates, fill, full, deepest hit.
        add_item(KIND_LOOKUP, 32'h0000_0005);
        add_item(KIND_PUSH,   32'h8000_0000);
        add_item(KIND_PUSH,   32'h7FFF_FFFF);
        add_item(KIND_PUSH,   32'h0000_0000);
        add_item(KIND_PUSH,   32'hFFFF_FFFF);
        add_item(KIND_PUSH,   32'h0000_0000);    // duplicate value
        add_item(KIND_LOOKUP, 32'h0000_0000);    // hit at the front
        add_item(KIND_LOOKUP, 32'h8000_0000);    // hit at the back
        add_item(KIND_LOOKUP, 32'h0000_0000);    // only the first of two matches moves
        add_item(KIND_LOOKUP, 32'h0000_3039);    // miss
        for (int k = 1; k <= DEPTH - 5; k++)
            add_item(KIND_PUSH, k * 32'h0101_0101 + 1);
        add_item(KIND_PUSH,   32'h5A5A_A5A5);    // rejected, list full
        add_item(KIND_LOOKUP, 32'h7FFF_FFFF);    // hit at the last cell
        add_item(KIND_LOOKUP, 32'hDEAD_0001);    // miss on a full list

        // Random: mostly hits on held values at random depths, mixed with misses
        // and pushes with arbitrary bit patterns.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            r = $urandom_range(0, 99);
            if (r < 60)
                add_item(KIND_LOOKUP, stored_keys[$urandom_range(0, stored_keys.size() - 1)]);
            else if (r < 80)
                add_item(KIND_LOOKUP, $urandom);
            else
                add_item(KIND_PUSH, $urandom);
        end

        while (!i_rst_n) @(negedge i_clk);
        while (cmd_queue.size() != 0 || start || due_results.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Checked %0d results: %0d pushes stored, %0d rejected as full,",
                 n_checked, n_stored, n_full);
        $display("%0d lookup hits, %0d misses, %0d lookups on an empty list.",
                 n_hit, n_miss, n_empty);
        if (n_fail == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: sim.f
design/mtf_pkg.sv
design/mtf_cell.sv
design/mtf_ctrl.sv
design/move_to_front_list_top.sv
bench/move_to_front_list_top_tb.sv
